// File: rtl/eased_glide_position_assert.svh
// Assertion macros shared by the eased glide position RTL.
// Each macro is live in simulation and empty for synthesis.
`ifndef EASED_GLIDE_POSITION_ASSERT_SVH
`define EASED_GLIDE_POSITION_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define EGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eased_glide_position: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define EGP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eased_glide_position: next-cycle check failed");

`else

`define EGP_ASSERT_IMP(lbl, ante, cons)
`define EGP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// File: rtl/egp_pkg.sv
package egp_pkg;

  // Field widths fixed by the item format
  localparam int TimeW  = 32;
  localparam int LenW   = 16;
  localparam int PixW   = 7;
  localparam int PhaseW = 8;

  // Quotient bits of elapsed*256/length
  localparam int DivSteps = 8;

  // Phase codes at the ends of the glide
  localparam logic [PhaseW-1:0] PHASE_START = 8'd0;
  localparam logic [PhaseW-1:0] PHASE_DONE  = 8'd255;

  // Smoothstep weight base: 765 - 2t
  localparam logic [9:0] EASE_BASE = 10'd765;

  // Per-item side information that rides along the pipeline
  typedef struct packed {
    logic            pending;  // glide not yet started
    logic            done;     // glide finished
    logic [PixW-1:0] from_x;
    logic [PixW-1:0] from_y;
    logic [PixW-1:0] to_x;
    logic [PixW-1:0] to_y;
  } egp_pass_t;

  // floor(m/255) for m up to 32639 (quotient fits in 7 bits), by reciprocal with rounding correction
  function automatic logic [PixW-1:0] egp_div255(input logic [14:0] m);
    logic [15:0] s;
    s = {1'b0, m} + {9'd0, m[14:8]} + 16'd1;
    return s[14:8];
  endfunction

endpackage

// File: rtl/egp_front.sv
module egp_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              now_time,
  input  logic [31:0]              glide_start,
  input  logic [15:0]              glide_length,
  input  logic [6:0]               from_x,
  input  logic [6:0]               from_y,
  input  logic [6:0]               to_x,
  input  logic [6:0]               to_y,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_rem,
  output logic [15:0]              out_len,
  output egp_pkg::egp_pass_t       out_pass
);
  import egp_pkg::*;

  logic [TimeW-1:0] diff_nxt;
  logic             pending_nxt;
  logic             done_nxt;
  logic             valid_r;
  logic [LenW-1:0]  rem_r;
  logic [LenW-1:0]  len_r;
  egp_pass_t        pass_r;

  // Wrap-safe elapsed time and the two end cases
  always_comb begin
    diff_nxt    = now_time - glide_start;
    pending_nxt = (diff_nxt == '0) || diff_nxt[TimeW-1];
    done_nxt    = !pending_nxt &&
                  ((diff_nxt[TimeW-2:LenW] != '0) || (diff_nxt[LenW-1:0] >= glide_length));
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Load the stage payload on every advance
  always_ff @(posedge clk) begin
    if (in_ready) begin
      rem_r          <= diff_nxt[LenW-1:0];
      len_r          <= glide_length;
      pass_r.pending <= pending_nxt;
      pass_r.done    <= done_nxt;
      pass_r.from_x  <= from_x;
      pass_r.from_y  <= from_y;
      pass_r.to_x    <= to_x;
      pass_r.to_y    <= to_y;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_len   = len_r;
  assign out_pass  = pass_r;

endmodule

// File: rtl/egp_div.sv
module egp_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [15:0]              in_rem,
  input  logic [15:0]              in_len,
  input  egp_pkg::egp_pass_t       in_pass,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_t,
  output egp_pkg::egp_pass_t       out_pass
);
  import egp_pkg::*;

  `include "eased_glide_position_assert.svh"

  logic                  v_r    [DivSteps];
  logic [LenW-1:0]       rem_r  [DivSteps];
  logic [LenW-1:0]       len_r  [DivSteps];
  logic [PhaseW-1:0]     q_r    [DivSteps];
  egp_pass_t             pass_r [DivSteps];
  logic                  en     [DivSteps+1];

  assign en[DivSteps] = out_ready;

  // One restoring-division step per stage, one quotient bit each
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic              v_prev;
    logic [LenW-1:0]   rem_prev;
    logic [LenW-1:0]   len_prev;
    logic [PhaseW-1:0] q_prev;
    egp_pass_t         pass_prev;
    logic [LenW:0]     rem2_nxt;
    logic              ge_nxt;
    logic [LenW-1:0]   rem_nxt;

    if (k == 0) begin : g_head
      assign v_prev    = in_valid;
      assign rem_prev  = in_rem;
      assign len_prev  = in_len;
      assign q_prev    = '0;
      assign pass_prev = in_pass;
    end else begin : g_body
      assign v_prev    = v_r[k-1];
      assign rem_prev  = rem_r[k-1];
      assign len_prev  = len_r[k-1];
      assign q_prev    = q_r[k-1];
      assign pass_prev = pass_r[k-1];
    end

    // Shift in a zero numerator bit, subtract the divisor where it fits
    always_comb begin
      rem2_nxt = {rem_prev, 1'b0};
      ge_nxt   = rem2_nxt >= {1'b0, len_prev};
      rem_nxt  = ge_nxt ? (rem2_nxt[LenW-1:0] - len_prev) : rem2_nxt[LenW-1:0];
    end

    assign en[k] = !v_r[k] || en[k+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt;
        len_r[k]  <= len_prev;
        q_r[k]    <= {q_prev[PhaseW-2:0], ge_nxt};
        pass_r[k] <= pass_prev;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DivSteps-1];
  assign out_t     = q_r[DivSteps-1];
  assign out_pass  = pass_r[DivSteps-1];

  // Inside the glide the remainder stays below the divisor
  `EGP_ASSERT_IMP(a_div_rem_below_len, v_r[DivSteps-1] && !pass_r[DivSteps-1].pending && !pass_r[DivSteps-1].done, rem_r[DivSteps-1] < len_r[DivSteps-1])
  // A stalled last stage keeps its beat
  `EGP_ASSERT_NXT(a_div_hold_on_stall, v_r[DivSteps-1] && !out_ready, v_r[DivSteps-1])

endmodule

// File: rtl/egp_ease.sv
module egp_ease (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_t,
  input  egp_pkg::egp_pass_t       in_pass,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_phase,
  output egp_pkg::egp_pass_t       out_pass
);
  import egp_pkg::*;

  `include "eased_glide_position_assert.svh"

  logic              v1_r;
  logic [15:0]       tt_r;
  logic [9:0]        w_r;
  egp_pass_t         pass1_r;
  logic              v2_r;
  logic [PhaseW-1:0] phase_r;
  egp_pass_t         pass2_r;
  logic              en1;
  logic              en2;
  logic [25:0]       prod_nxt;
  logic [PhaseW-1:0] phase_nxt;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Square t and form the weight 765 - 2t
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tt_r    <= {8'd0, in_t} * {8'd0, in_t};
      w_r     <= EASE_BASE - {1'b0, in_t, 1'b0};
      pass1_r <= in_pass;
    end
  end

  // Apply the weight and pick the end cases
  always_comb begin
    prod_nxt = {10'd0, tt_r} * {16'd0, w_r};
    if (pass1_r.pending) begin
      phase_nxt = PHASE_START;
    end else if (pass1_r.done) begin
      phase_nxt = PHASE_DONE;
    end else begin
      phase_nxt = prod_nxt[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      phase_r <= phase_nxt;
      pass2_r <= pass1_r;
    end
  end

  assign out_valid = v2_r;
  assign out_phase = phase_r;
  assign out_pass  = pass2_r;

  // A finished glide always reads full phase
  `EGP_ASSERT_IMP(a_ease_done_full, v2_r && pass2_r.done, phase_r == PHASE_DONE)
  // The curve itself never reaches full phase
  `EGP_ASSERT_IMP(a_ease_curve_peak, v2_r && !pass2_r.pending && !pass2_r.done, phase_r <= 8'd253)

endmodule

// File: rtl/egp_mix.sv
module egp_mix (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_phase,
  input  egp_pkg::egp_pass_t       in_pass,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [6:0]               pos_x,
  output logic [6:0]               pos_y,
  output logic [7:0]               phase
);
  import egp_pkg::*;

  logic              v1_r;
  logic [14:0]       mag_x_r;
  logic [14:0]       mag_y_r;
  logic              neg_x_r;
  logic              neg_y_r;
  logic [PixW-1:0]   from_x_r;
  logic [PixW-1:0]   from_y_r;
  logic [PhaseW-1:0] phase1_r;
  logic              v2_r;
  logic [PixW-1:0]   pos_x_r;
  logic [PixW-1:0]   pos_y_r;
  logic [PhaseW-1:0] phase2_r;
  logic              en1;
  logic              en2;
  logic [PixW:0]     span_x_nxt;
  logic [PixW:0]     span_y_nxt;
  logic [PixW-1:0]   abs_x_nxt;
  logic [PixW-1:0]   abs_y_nxt;
  logic [PixW-1:0]   q_x_nxt;
  logic [PixW-1:0]   q_y_nxt;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Split each span into sign and magnitude
  always_comb begin
    span_x_nxt = {1'b0, in_pass.to_x} - {1'b0, in_pass.from_x};
    span_y_nxt = {1'b0, in_pass.to_y} - {1'b0, in_pass.from_y};
    abs_x_nxt  = span_x_nxt[PixW] ? (in_pass.from_x - in_pass.to_x) : span_x_nxt[PixW-1:0];
    abs_y_nxt  = span_y_nxt[PixW] ? (in_pass.from_y - in_pass.to_y) : span_y_nxt[PixW-1:0];
  end

  // Scale the span magnitudes by the phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mag_x_r  <= {8'd0, abs_x_nxt} * {7'd0, in_phase};
      mag_y_r  <= {8'd0, abs_y_nxt} * {7'd0, in_phase};
      neg_x_r  <= span_x_nxt[PixW];
      neg_y_r  <= span_y_nxt[PixW];
      from_x_r <= in_pass.from_x;
      from_y_r <= in_pass.from_y;
      phase1_r <= in_phase;
    end
  end

  // Divide by 255 toward zero and step from the start pixel
  always_comb begin
    q_x_nxt = egp_div255(mag_x_r);
    q_y_nxt = egp_div255(mag_y_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      pos_x_r  <= neg_x_r ? (from_x_r - q_x_nxt) : (from_x_r + q_x_nxt);
      pos_y_r  <= neg_y_r ? (from_y_r - q_y_nxt) : (from_y_r + q_y_nxt);
      phase2_r <= phase1_r;
    end
  end

  assign out_valid = v2_r;
  assign pos_x     = pos_x_r;
  assign pos_y     = pos_y_r;
  assign phase     = phase2_r;

endmodule

// File: rtl/eased_glide_position.sv
// Eased glide position: smoothstep-eased pixel position of one dot per beat.
//
// Input stream (in_*): one beat per dot with the current time, the glide start
// time, the glide length and the start and target pixels. Output stream
// (out_*): one beat per input beat, in order, with the eased pixel column, row
// and the eased phase (0 before the glide, 255 once it has finished).
//
// Pipeline: an accepted input beat passes through the elapsed-time subtract and
// end-case compares, the divider (one quotient bit per stage), the smoothstep
// multiplies and the coordinate scale and divide by 255, in that order.
// Throughput: one beat per cycle while the receiver does not stall; every
// stage is a registered step.
//
// Reset clears every stage's valid bit; the pipeline holds no other state.
// When the receiver stalls, the last stage holds its beat and earlier stages
// keep advancing into empty stages, so in_tready stays high until the whole
// pipeline is full.
module eased_glide_position (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // now_time[31:0], glide_start[63:32], glide_length[79:64], from_x[86:80],
  // from_y[93:87], to_x[100:94], to_y[107:101], zero fill [111:108]
  input  logic [111:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // pos_x[6:0], pos_y[13:7], phase[21:14], zero fill [23:22]
  output logic [23:0]   out_tdata
);
  import egp_pkg::*;

  logic              fr_valid;
  logic              fr_ready;
  logic [LenW-1:0]   fr_rem;
  logic [LenW-1:0]   fr_len;
  egp_pass_t         fr_pass;
  logic              dv_valid;
  logic              dv_ready;
  logic [PhaseW-1:0] dv_t;
  egp_pass_t         dv_pass;
  logic              es_valid;
  logic              es_ready;
  logic [PhaseW-1:0] es_phase;
  egp_pass_t         es_pass;
  logic [PixW-1:0]   pos_x;
  logic [PixW-1:0]   pos_y;
  logic [PhaseW-1:0] phase;

  // Elapsed time and end cases
  egp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .now_time     (in_tdata[31:0]),
    .glide_start  (in_tdata[63:32]),
    .glide_length (in_tdata[79:64]),
    .from_x       (in_tdata[86:80]),
    .from_y       (in_tdata[93:87]),
    .to_x         (in_tdata[100:94]),
    .to_y         (in_tdata[107:101]),
    .out_valid    (fr_valid),
    .out_ready    (fr_ready),
    .out_rem      (fr_rem),
    .out_len      (fr_len),
    .out_pass     (fr_pass)
  );

  // Linear fraction elapsed*256/length
  egp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_rem    (fr_rem),
    .in_len    (fr_len),
    .in_pass   (fr_pass),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_t     (dv_t),
    .out_pass  (dv_pass)
  );

  // Smoothstep phase
  egp_ease u_ease (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_t      (dv_t),
    .in_pass   (dv_pass),
    .out_valid (es_valid),
    .out_ready (es_ready),
    .out_phase (es_phase),
    .out_pass  (es_pass)
  );

  // Coordinate interpolation and output register
  egp_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (es_valid),
    .in_ready  (es_ready),
    .in_phase  (es_phase),
    .in_pass   (es_pass),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .phase     (phase)
  );

  assign out_tdata = {2'b00, phase, pos_y, pos_x};

endmodule

// File: tb/eased_glide_position_tb.sv
`timescale 1ns / 100ps

module eased_glide_position_tb;
  import egp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 450;
  localparam int DrainCycles = 40;

  typedef struct packed {
    logic [TimeW-1:0] now_time;
    logic [TimeW-1:0] glide_start;
    logic [LenW-1:0]  glide_length;
    logic [PixW-1:0]  from_x;
    logic [PixW-1:0]  from_y;
    logic [PixW-1:0]  to_x;
    logic [PixW-1:0]  to_y;
  } glide_item_t;

  typedef struct packed {
    logic [PixW-1:0]   pos_x;
    logic [PixW-1:0]   pos_y;
    logic [PhaseW-1:0] phase;
  } glide_pos_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  // Predict eased positions and compare them against the output stream in order
  class glide_scoreboard;
    glide_pos_t expected_q[$];
    int errors = 0;

    function logic [PhaseW-1:0] eased_phase(glide_item_t it);
      logic [TimeW-1:0] elapsed;
      logic [23:0] scaled;
      int unsigned t;
      int unsigned curve;
      elapsed = it.now_time - it.glide_start;
      if (elapsed == 0 || elapsed[TimeW-1]) return PHASE_START;
      if (elapsed >= it.glide_length) return PHASE_DONE;
      // inside the glide elapsed fits in 16 bits, so the shifted value is exact
      scaled = {elapsed[LenW-1:0], 8'd0} / {8'd0, it.glide_length};
      t = {24'd0, scaled[7:0]};
      curve = t * t * (765 - 2 * t);
      return curve[23:16];
    endfunction

    function logic [PixW-1:0] glide_coord(logic [PixW-1:0] start_px, logic [PixW-1:0] end_px,
                                          logic [PhaseW-1:0] ph);
      int base;
      int span;
      int v;
      base = int'(start_px);
      span = int'(end_px) - base;
      // int division truncates toward zero
      v = base + (span * int'(ph)) / 255;
      return v[PixW-1:0];
    endfunction

    function glide_pos_t eased_position(glide_item_t it);
      glide_pos_t r;
      r.phase = eased_phase(it);
      r.pos_x = glide_coord(it.from_x, it.to_x, r.phase);
      r.pos_y = glide_coord(it.from_y, it.to_y, r.phase);
      return r;
    endfunction

    function void note_input(glide_item_t it);
      expected_q.push_back(eased_position(it));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(glide_pos_t got);
      glide_pos_t exp_pos;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual x=%0d y=%0d phase=%0d",
                 $time, got.pos_x, got.pos_y, got.phase);
        errors++;
        return;
      end
      exp_pos = expected_q.pop_front();
      compare_field("pos_x", int'(exp_pos.pos_x), int'(got.pos_x));
      compare_field("pos_y", int'(exp_pos.pos_y), int'(got.pos_y));
      compare_field("phase", int'(exp_pos.phase), int'(got.phase));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [23:0]  out_tdata;

  glide_scoreboard sb = new();
  glide_item_t stim_q[$];
  int in_beats = 0;
  int cycle_count = 0;

  eased_glide_position dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Give up on a hung pipeline
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [111:0] item_beat(glide_item_t it);
    return {4'd0, it.to_y, it.to_x, it.from_y, it.from_x,
            it.glide_length, it.glide_start, it.now_time};
  endfunction

  function automatic glide_item_t beat_item(logic [111:0] d);
    glide_item_t it;
    it.now_time     = d[31:0];
    it.glide_start  = d[63:32];
    it.glide_length = d[79:64];
    it.from_x       = d[86:80];
    it.from_y       = d[93:87];
    it.to_x         = d[100:94];
    it.to_y         = d[107:101];
    return it;
  endfunction

  function automatic glide_pos_t beat_pos(logic [23:0] d);
    glide_pos_t p;
    p.pos_x = d[6:0];
    p.pos_y = d[13:7];
    p.phase = d[21:14];
    return p;
  endfunction

  // Observe accepted beats on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_input(beat_item(in_tdata));
        in_beats <= in_beats + 1;
      end
      if (out_tvalid && out_tready) sb.check_result(beat_pos(out_tdata));
    end
  end

  // Receiver backpressure: changing stall modes plus one long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int rx_mode_left = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (!held_once && in_beats >= 120) begin
      held_once = 1'b1;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(10, 60);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic add_item(logic [31:0] now_t, logic [31:0] start_t, logic [15:0] len,
                          logic [6:0] fx, logic [6:0] fy, logic [6:0] tx, logic [6:0] ty);
    glide_item_t it;
    it.now_time = now_t;
    it.glide_start = start_t;
    it.glide_length = len;
    it.from_x = fx;
    it.from_y = fy;
    it.to_x = tx;
    it.to_y = ty;
    stim_q.push_back(it);
  endtask

  function automatic glide_item_t random_glide();
    glide_item_t it;
    int unsigned pick;
    logic [31:0] elapsed;
    pick = $urandom_range(0, 99);
    it.glide_length = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 16))
                                                  : 16'($urandom_range(0, 65535));
    it.glide_start = $urandom;
    // mostly inside the glide, some not yet started, some anywhere
    if (pick < 70) elapsed = $urandom_range(0, int'(it.glide_length) + 2);
    else if (pick < 85) elapsed = -$urandom_range(1, 5000);
    else elapsed = $urandom;
    it.now_time = it.glide_start + elapsed;
    it.from_x = 7'($urandom_range(0, 127));
    it.from_y = 7'($urandom_range(0, 127));
    it.to_x = 7'($urandom_range(0, 127));
    it.to_y = 7'($urandom_range(0, 127));
    return it;
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(glide_item_t it);
    in_tdata <= item_beat(it);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int idx;
    int burst;
    int gap;

    // not yet started, both at zero difference and negative
    add_item(32'd1000, 32'd1000, 16'd100, 7'd0, 7'd0, 7'd127, 7'd127);
    add_item(32'd999, 32'd1000, 16'd100, 7'd127, 7'd127, 7'd0, 7'd0);
    add_item(32'h8000_0000, 32'd0, 16'd65535, 7'd10, 7'd20, 7'd90, 7'd100);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd65535, 7'd127, 7'd0, 7'd0, 7'd127);
    // first step into the glide and the top of the curve
    add_item(32'd1001, 32'd1000, 16'd100, 7'd0, 7'd127, 7'd127, 7'd0);
    add_item(32'd1, 32'd0, 16'd65535, 7'd0, 7'd0, 7'd127, 7'd127);
    add_item(32'd1099, 32'd1000, 16'd100, 7'd0, 7'd127, 7'd127, 7'd0);
    add_item(32'd65534, 32'd0, 16'd65535, 7'd0, 7'd127, 7'd127, 7'd0);
    // finished, zero length, far past the end
    add_item(32'd1100, 32'd1000, 16'd100, 7'd3, 7'd4, 7'd120, 7'd5);
    add_item(32'd1001, 32'd1000, 16'd0, 7'd127, 7'd127, 7'd0, 7'd0);
    add_item(32'd1000, 32'd1000, 16'd0, 7'd127, 7'd127, 7'd0, 7'd0);
    add_item(32'h7FFF_FFFF, 32'd0, 16'd65535, 7'd1, 7'd2, 7'd126, 7'd125);
    // time wrapping past the top
    add_item(32'h0000_0010, 32'hFFFF_FFF0, 16'd64, 7'd0, 7'd127, 7'd127, 7'd0);
    // midpoints with negative spans, no span and a one-pixel span
    add_item(32'd50, 32'd0, 16'd100, 7'd127, 7'd0, 7'd0, 7'd127);
    add_item(32'd3, 32'd0, 16'd7, 7'd64, 7'd64, 7'd64, 7'd64);
    add_item(32'd40, 32'd0, 16'd80, 7'd5, 7'd6, 7'd6, 7'd5);
    add_item(32'd2, 32'd0, 16'd3, 7'd100, 7'd17, 7'd33, 7'd99);
    repeat (RandomItems) stim_q.push_back(random_glide());

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Feed beats in bursts with random gaps; some gaps are empty
    idx = 0;
    while (idx < stim_q.size()) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && idx < stim_q.size()) begin
        send_beat(stim_q[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 || idx == stim_q.size()) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // Drain the pipeline, then allow for stray beats
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/egp_pkg.sv
rtl/egp_front.sv
rtl/egp_div.sv
rtl/egp_ease.sv
rtl/egp_mix.sv
rtl/eased_glide_position.sv
tb/eased_glide_position_tb.sv
